### rtl/ftrm_pkg.sv
// ----------------------------------------------------------------------------
// Fan tach RPM meter package
// Field widths, register reset values and register indexes shared by the
// channel interfaces and the meter core.
// ----------------------------------------------------------------------------
package ftrm_pkg;

    localparam int TS_W      = 32;   // timestamp field
    localparam int SPEED_W   = 26;   // speed field
    localparam int HOLDOFF_W = 20;
    localparam int THRESH_W  = 8;
    localparam int STALL_W   = 27;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 27;   // widest register

    localparam logic [HOLDOFF_W-1:0] HOLDOFF_RST = HOLDOFF_W'(2500);
    localparam logic [THRESH_W-1:0]  THRESH_RST  = THRESH_W'(16);
    localparam logic [STALL_W-1:0]   STALL_RST   = STALL_W'(200000);

    // Dividend of the speed measurement: microseconds per minute
    localparam logic [SPEED_W-1:0]   SPEED_NUM   = SPEED_W'(60000000);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STALL   = 2'd2;

    // Item operation codes
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_POLL = 1'b1;

endpackage

### rtl/ftrm_in_if.sv
// ----------------------------------------------------------------------------
// Fan tach RPM meter input channel
// Carries one tach edge or stall poll request with its timestamp.
// ----------------------------------------------------------------------------
interface ftrm_in_if;
    import ftrm_pkg::*;

    logic            valid;
    logic            ready;
    logic            operation;
    logic [TS_W-1:0] timestamp_us;

    modport source (output valid, output operation, output timestamp_us, input ready);
    modport sink   (input valid, input operation, input timestamp_us, output ready);

endinterface

### rtl/ftrm_out_if.sv
// ----------------------------------------------------------------------------
// Fan tach RPM meter result channel
// Carries the speed and status flags produced for one request.
// ----------------------------------------------------------------------------
interface ftrm_out_if;
    import ftrm_pkg::*;

    logic               valid;
    logic               ready;
    logic [SPEED_W-1:0] speed_rpm;
    logic               edge_accepted;
    logic               speed_updated;
    logic               stalled;

    modport source (output valid, output speed_rpm, output edge_accepted,
                    output speed_updated, output stalled, input ready);
    modport sink   (input valid, input speed_rpm, input edge_accepted,
                    input speed_updated, input stalled, output ready);

endinterface

### rtl/ftrm_cfg_if.sv
// ----------------------------------------------------------------------------
// Fan tach RPM meter configuration channel
// Carries one register write: register index and write data.
// ----------------------------------------------------------------------------
interface ftrm_cfg_if;
    import ftrm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

### rtl/fan_tach_rpm_meter.sv
// ----------------------------------------------------------------------------
// Fan tach RPM meter
// Measures fan speed from time-stamped tach edges, with holdoff filtering
// and stall detection, using one shared subtractor under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : requests of a tach falling edge (operation 0) or a stall poll
//           (operation 1), each with a free-running microsecond timestamp.
//   o_out : exactly one result per request: current speed in RPM and the
//           edge_accepted / speed_updated / stalled flags.
//   i_cfg : register writes (0 holdoff_us, 1 edge_threshold,
//           2 stall_timeout_us); always ready, other indexes are dropped.
// Sequencing:
//   A poll steps through S_WIN and S_SCMP, an edge that makes no
//   measurement through S_HOLD and S_HCMP, and an edge that makes one also
//   through S_WIN and the 26 restoring-division steps that reuse the single
//   subtractor; S_OUT then loads the output register. One request is in
//   work at a time; i_in.ready is high only while the sequencer is idle, so
//   the next request is taken in the cycle after the result is registered.
// Reset: i_rst_n low clears times, edge count and speed to zero and loads
//   the register defaults (2500, 16, 200000).
// Stall on o_out: a finished result waits in the output register; the
//   next request may be accepted meanwhile but holds in its last step
//   until the output register is free.
// ----------------------------------------------------------------------------
module fan_tach_rpm_meter #(
    parameter int TIME_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ftrm_in_if.sink           i_in,
    ftrm_out_if.source        o_out,
    ftrm_cfg_if.sink          i_cfg
);
    import ftrm_pkg::*;

    // Subtractor width: holds a shifted division remainder and the widest
    // register compared against a time difference.
    localparam int RW    = ((TIME_BITS > STALL_W) ? TIME_BITS : STALL_W) + 1;
    localparam int CNT_W = $clog2(SPEED_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SPEED_W - 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,  // wait for a request
        S_HOLD = 7'b0000010,  // now - accept_time
        S_HCMP = 7'b0000100,  // holdoff compare
        S_WIN  = 7'b0001000,  // now - window_start
        S_SCMP = 7'b0010000,  // stall compare
        S_DIV  = 7'b0100000,  // one division step per cycle
        S_OUT  = 7'b1000000   // hand result to the output register
    } t_state;

    t_state r_state, n_state;

    // Configuration registers
    logic [HOLDOFF_W-1:0] r_holdoff;
    logic [THRESH_W-1:0]  r_thresh;
    logic [STALL_W-1:0]   r_stall_to;

    // Meter state
    logic [TIME_BITS-1:0] r_accept_time;
    logic [TIME_BITS-1:0] r_window_start;
    logic [7:0]           r_edge_count;
    logic [SPEED_W-1:0]   r_speed;

    // Request in work
    logic                 r_op;
    logic [TIME_BITS-1:0] r_now;
    logic [TIME_BITS-1:0] r_diff;
    logic                 r_acc;
    logic                 r_upd;
    logic                 r_stl;

    // Divider
    logic [RW-1:0]        r_rem;
    logic [SPEED_W-1:0]   r_quo;
    logic [CNT_W-1:0]     r_cnt;

    // Output register
    logic                 r_ov;
    logic [SPEED_W-1:0]   r_o_speed;
    logic                 r_o_acc;
    logic                 r_o_upd;
    logic                 r_o_stl;

    // Shared subtractor
    logic [RW-1:0]        sub_a;
    logic [RW-1:0]        sub_b;
    logic [RW:0]          sub_res;
    logic                 sub_borrow;
    logic [TIME_BITS-1:0] sub_time;

    logic                 in_fire;
    logic                 out_free;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_ov || o_out.ready;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid         = r_ov;
    assign o_out.speed_rpm     = r_o_speed;
    assign o_out.edge_accepted = r_o_acc;
    assign o_out.speed_updated = r_o_upd;
    assign o_out.stalled       = r_o_stl;

    // Select subtractor operands for the current step
    always_comb begin
        sub_a = '0;
        sub_b = '0;
        case (r_state)
            S_HOLD: begin
                sub_a = RW'(r_now);
                sub_b = RW'(r_accept_time);
            end
            S_HCMP: begin
                sub_a = RW'(r_diff);
                sub_b = RW'(r_holdoff);
            end
            S_WIN: begin
                sub_a = RW'(r_now);
                sub_b = RW'(r_window_start);
            end
            S_SCMP: begin
                sub_a = RW'(r_stall_to);
                sub_b = RW'(r_diff);
            end
            S_DIV: begin
                sub_a = {r_rem[RW-2:0], r_quo[SPEED_W-1]};
                sub_b = RW'(r_diff);
            end
            default: begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    assign sub_res    = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_borrow = sub_res[RW];
    assign sub_time   = sub_res[TIME_BITS-1:0];   // wraps modulo 2^TIME_BITS

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = (i_in.operation == OP_EDGE) ? S_HOLD : S_WIN;
                end
            end
            S_HOLD: n_state = S_HCMP;
            S_HCMP: begin
                if (sub_borrow) begin
                    n_state = S_OUT;            // inside holdoff: drop edge
                end else if (r_edge_count > r_thresh) begin
                    n_state = S_WIN;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_WIN:  n_state = (r_op == OP_POLL) ? S_SCMP : S_DIV;
            S_SCMP: n_state = S_OUT;
            S_DIV: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_holdoff      <= HOLDOFF_RST;
            r_thresh       <= THRESH_RST;
            r_stall_to     <= STALL_RST;
            r_accept_time  <= '0;
            r_window_start <= '0;
            r_edge_count   <= '0;
            r_speed        <= '0;
            r_ov           <= 1'b0;
        end else begin
            r_state <= n_state;

            // Register writes
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_HOLDOFF: r_holdoff  <= i_cfg.data[HOLDOFF_W-1:0];
                    REG_THRESH:  r_thresh   <= i_cfg.data[THRESH_W-1:0];
                    REG_STALL:   r_stall_to <= i_cfg.data[STALL_W-1:0];
                    default: ;
                endcase
            end

            // Load the output register, or release it once taken
            if (r_state == S_OUT && out_free) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                S_HOLD: begin
                    r_edge_count <= r_edge_count + 8'd1;   // counts every edge
                end
                S_HCMP: begin
                    if (!sub_borrow) begin
                        r_accept_time <= r_now;
                    end
                end
                S_DIV: begin
                    if (r_cnt == CNT_LAST) begin
                        r_speed        <= {r_quo[SPEED_W-2:0], !sub_borrow};
                        r_window_start <= r_now;
                        r_edge_count   <= '0;
                    end
                end
                S_SCMP: begin
                    if (sub_borrow) begin
                        r_speed <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers of the request in work
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    r_op  <= i_in.operation;
                    r_now <= TIME_BITS'(i_in.timestamp_us);
                    r_acc <= 1'b0;
                    r_upd <= 1'b0;
                    r_stl <= 1'b0;
                end
            end
            S_HOLD: begin
                r_diff <= sub_time;
            end
            S_HCMP: begin
                r_acc <= !sub_borrow;
            end
            S_WIN: begin
                // For an edge, zero elapsed time counts as one microsecond
                if (r_op == OP_EDGE && sub_time == '0) begin
                    r_diff <= TIME_BITS'(1);
                end else begin
                    r_diff <= sub_time;
                end
                r_rem <= '0;
                r_quo <= SPEED_NUM;
                r_cnt <= '0;
            end
            S_SCMP: begin
                r_stl <= sub_borrow;
            end
            S_DIV: begin
                // Restoring step: keep the trial remainder when it fits
                r_rem <= sub_borrow ? sub_a : sub_res[RW-1:0];
                r_quo <= {r_quo[SPEED_W-2:0], !sub_borrow};
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    r_upd <= 1'b1;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    r_o_speed <= r_speed;
                    r_o_acc   <= r_acc;
                    r_o_upd   <= r_upd;
                    r_o_stl   <= r_stl;
                end
            end
            default: ;
        endcase
    end

endmodule
